// ----- design/bdpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants of the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  // Width of the quiet-time and hold-time counters (range 8 to 32).
  localparam int unsigned CountBits  = 16;
  // Width of the threshold registers.
  localparam int unsigned ThreshBits = 16;
  // Width at which counters and thresholds are compared.
  localparam int unsigned CmpBits    = (CountBits > ThreshBits) ? CountBits : ThreshBits;

  typedef logic [CountBits-1:0]  count_t;
  typedef logic [ThreshBits-1:0] thresh_t;
  typedef logic [CmpBits-1:0]    cmp_t;

  localparam count_t CntMax = {CountBits{1'b1}};

  // Reset values of the threshold registers.
  localparam thresh_t DebounceReset = ThreshBits'(50);
  localparam thresh_t LongReset     = ThreshBits'(1000);
  localparam thresh_t VeryLongReset = ThreshBits'(5000);

  localparam int unsigned CfgIndexBits = 2;

  typedef enum logic [CfgIndexBits-1:0] {
    RegDebounce = 2'd0,
    RegLong     = 2'd1,
    RegVeryLong = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EvNone     = 2'd0,
    EvClick    = 2'd1,
    EvLong     = 2'd2,
    EvVeryLong = 2'd3
  } press_event_e;

  // Saturating increment of a counter.
  function automatic count_t sat_inc(input count_t v);
    sat_inc = (v == CntMax) ? v : v + count_t'(1);
  endfunction

endpackage

// ----- design/button_debounce_press_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces an active-low button sample stream and classifies presses.
// Each sample passes through the input register, then the result register,
// and a stalled result holds it between them; one item per cycle sustained
// while the result stream is not stalled, as the state updates per transfer.
// Reset (async, active low): level released, counters and flags cleared,
// thresholds 50 / 1000 / 5000 ticks.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  // raw sample stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [0] raw_level, [7:1] zero
  // result stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [1:0] press_event, [2] held_now, [7:3] zero
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bdpc_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  logic [bdpc_pkg::ThreshBits-1:0]   cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; unknown indices drop.
  // --------------------------------------------------------------------------
  bdpc_pkg::thresh_t debounce_q, long_q, very_long_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= bdpc_pkg::DebounceReset;
      long_q      <= bdpc_pkg::LongReset;
      very_long_q <= bdpc_pkg::VeryLongReset;
    end else if (cfg_valid_i) begin
      unique case (bdpc_pkg::cfg_reg_e'(cfg_index_i))
        bdpc_pkg::RegDebounce: debounce_q  <= cfg_data_i;
        bdpc_pkg::RegLong:     long_q      <= cfg_data_i;
        bdpc_pkg::RegVeryLong: very_long_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. The input register holds one sample; it moves into the result
  // register (and updates the state) whenever that register is free or being
  // drained. So one sample may be taken while a result is stalled.
  // --------------------------------------------------------------------------
  logic in_valid_q, in_level_q;
  logic out_valid_q;
  logic advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_level_q <= s_axis_tdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Debounce and classification state.
  // --------------------------------------------------------------------------
  logic                    prev_q, prev_d;
  logic                    stable_q, stable_d;
  bdpc_pkg::count_t        quiet_q, quiet_d;
  bdpc_pkg::count_t        hold_q, hold_d;
  logic                    long_done_q, long_done_d;
  logic                    vlong_done_q, vlong_done_d;
  bdpc_pkg::press_event_e  event_d, event_q;
  logic                    level_change;

  always_comb begin
    prev_d       = in_level_q;
    stable_d     = stable_q;
    long_done_d  = long_done_q;
    vlong_done_d = vlong_done_q;
    event_d      = bdpc_pkg::EvNone;

    // a change of the raw sample restarts the quiet time
    quiet_d = (in_level_q != prev_q) ? '0 : bdpc_pkg::sat_inc(quiet_q);
    hold_d  = bdpc_pkg::sat_inc(hold_q);

    level_change = (bdpc_pkg::cmp_t'(quiet_d) > bdpc_pkg::cmp_t'(debounce_q))
                   && (in_level_q != stable_q);

    if (level_change) begin
      stable_d = in_level_q;
      if (!in_level_q) begin
        // new press: restart hold time, rearm both actions
        hold_d       = '0;
        long_done_d  = 1'b0;
        vlong_done_d = 1'b0;
      end else if (!long_done_q && !vlong_done_q) begin
        event_d = bdpc_pkg::EvClick;
      end
    end

    if (!stable_d) begin
      if (!vlong_done_d
          && (bdpc_pkg::cmp_t'(hold_d) >= bdpc_pkg::cmp_t'(very_long_q))) begin
        // very long press also counts as the long action
        vlong_done_d = 1'b1;
        long_done_d  = 1'b1;
        event_d      = bdpc_pkg::EvVeryLong;
      end else if (!long_done_d
                   && (bdpc_pkg::cmp_t'(hold_d) >= bdpc_pkg::cmp_t'(long_q))) begin
        long_done_d = 1'b1;
        event_d     = bdpc_pkg::EvLong;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= 1'b1;
      stable_q     <= 1'b1;
      quiet_q      <= '0;
      hold_q       <= '0;
      long_done_q  <= 1'b0;
      vlong_done_q <= 1'b0;
    end else if (advance) begin
      prev_q       <= prev_d;
      stable_q     <= stable_d;
      quiet_q      <= quiet_d;
      hold_q       <= hold_d;
      long_done_q  <= long_done_d;
      vlong_done_q <= vlong_done_d;
    end
  end

  // result payload; held level is read straight from the stable state
  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_q <= event_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, !stable_q, event_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_vlong_implies_long: assert property (
    @(posedge clk_i) disable iff (!rst_ni) vlong_done_q |-> long_done_q)
    else $error("very long flag set without long flag");

  a_hold_events_pressed: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (event_q == bdpc_pkg::EvLong || event_q == bdpc_pkg::EvVeryLong))
    |-> !stable_q)
    else $error("hold event reported while released");

  a_click_released: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && event_q == bdpc_pkg::EvClick) |-> stable_q)
    else $error("click reported while pressed");

  a_state_moves_with_transfer: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(stable_q) && $stable(hold_q) && $stable(quiet_q)))
    else $error("state changed without an item moving to the result register");

endmodule

// ----- bench/bdpc_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_result_checker
// Tracks the debounce and press state of the classifier from the sample,
// result and configuration transfers seen on its ports. It forecasts the
// event code and debounced level for every accepted sample and matches
// them, in order, against the result transfers.
// ----------------------------------------------------------------------------
module bdpc_result_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid_i,
  input  logic                              s_tready_i,
  input  logic [7:0]                        s_tdata_i,   // [0] raw_level
  input  logic                              m_tvalid_i,
  input  logic                              m_tready_i,
  input  logic [7:0]                        m_tdata_i,   // [1:0] press_event, [2] held_now
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [bdpc_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  logic [bdpc_pkg::ThreshBits-1:0]   cfg_data_i,
  output int                                mismatch_count_o,
  output int                                pending_o
);

  typedef struct packed {
    bdpc_pkg::press_event_e ev;
    logic                   held;
  } tick_result_t;

  bdpc_pkg::thresh_t debounce_thr;
  bdpc_pkg::thresh_t long_thr;
  bdpc_pkg::thresh_t very_long_thr;

  logic             last_raw;
  logic             debounced;      // 1 = released
  bdpc_pkg::count_t quiet_age;
  bdpc_pkg::count_t hold_age;
  logic             long_seen;
  logic             very_long_seen;

  tick_result_t awaited_results[$];

  function automatic bdpc_pkg::count_t bump(input bdpc_pkg::count_t v);
    return (v == bdpc_pkg::CntMax) ? v : bdpc_pkg::count_t'(v + 1'b1);
  endfunction

  // One tick of the debouncer and classifier.
  function automatic tick_result_t classify_tick(input logic raw);
    tick_result_t r;
    r.ev = bdpc_pkg::EvNone;
    if (raw != last_raw) begin
      quiet_age = '0;
      last_raw  = raw;
    end else begin
      quiet_age = bump(quiet_age);
    end
    hold_age = bump(hold_age);

    if (bdpc_pkg::cmp_t'(quiet_age) > bdpc_pkg::cmp_t'(debounce_thr)
        && raw != debounced) begin
      debounced = raw;
      if (!debounced) begin
        hold_age       = '0;
        long_seen      = 1'b0;
        very_long_seen = 1'b0;
      end else if (!long_seen && !very_long_seen) begin
        r.ev = bdpc_pkg::EvClick;
      end
    end

    if (!debounced) begin
      if (!very_long_seen
          && bdpc_pkg::cmp_t'(hold_age) >= bdpc_pkg::cmp_t'(very_long_thr)) begin
        very_long_seen = 1'b1;
        long_seen      = 1'b1;
        r.ev           = bdpc_pkg::EvVeryLong;
      end else if (!long_seen
                   && bdpc_pkg::cmp_t'(hold_age) >= bdpc_pkg::cmp_t'(long_thr)) begin
        long_seen = 1'b1;
        r.ev      = bdpc_pkg::EvLong;
      end
    end
    r.held = ~debounced;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input tick_result_t want,
                               input tick_result_t got);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) begin
      $display("mismatch %0d at %0t: %s, event exp %0d got %0d, held exp %0b got %0b",
               mismatch_count_o, $realtime, what, want.ev, got.ev, want.held, got.held);
    end
  endtask

  always @(posedge clk_i) begin
    tick_result_t got;
    tick_result_t want;
    if (!rst_ni) begin
      debounce_thr   = bdpc_pkg::DebounceReset;
      long_thr       = bdpc_pkg::LongReset;
      very_long_thr  = bdpc_pkg::VeryLongReset;
      last_raw       = 1'b1;
      debounced      = 1'b1;
      quiet_age      = '0;
      hold_age       = '0;
      long_seen      = 1'b0;
      very_long_seen = 1'b0;
      awaited_results.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == bdpc_pkg::RegDebounce) debounce_thr = cfg_data_i;
        else if (cfg_index_i == bdpc_pkg::RegLong) long_thr = cfg_data_i;
        else if (cfg_index_i == bdpc_pkg::RegVeryLong) very_long_thr = cfg_data_i;
      end

      // Results are matched before this edge's sample is forecast.
      if (m_tvalid_i && m_tready_i) begin
        got.ev   = bdpc_pkg::press_event_e'(m_tdata_i[1:0]);
        got.held = m_tdata_i[2];
        if (awaited_results.size() == 0) begin
          want = '0;
          flag_mismatch("result with nothing outstanding", want, got);
        end else begin
          want = awaited_results.pop_front();
          if (got.ev != want.ev || got.held != want.held) begin
            flag_mismatch("wrong result", want, got);
          end
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        awaited_results.push_back(classify_tick(s_tdata_i[0]));
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

// ----- bench/button_debounce_press_classifier_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_tb
// Drives raw button samples and threshold writes into the classifier and
// leaves forecasting and matching to bdpc_result_checker. A short directed
// run hits zero, crossed and unreachable thresholds, then press, bounce and
// release traffic runs under several threshold sets and handshake paces.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_tb;

  localparam int ClkHalf       = 6;
  localparam int ResetCycles   = 12;
  localparam int CycleLimit    = 400000;
  localparam int SettleCycles  = 4;      // result path is two stages deep
  localparam int HoldOffStart  = 1150;   // samples sent before the long stall
  localparam int HoldOffCycles = 300;

  // Index past the register map; writes there must be dropped.
  localparam logic [bdpc_pkg::CfgIndexBits-1:0] RegSpare = 2'd3;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // All block inputs start at known values.
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [7:0]                        s_axis_tdata  = 8'h01;  // [0] raw_level, [7:1] zero
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [7:0]                        m_axis_tdata;   // [1:0] press_event, [2] held_now
  logic                              cfg_valid_i   = 1'b0;
  logic                              cfg_ready_o;
  logic [bdpc_pkg::CfgIndexBits-1:0] cfg_index_i   = bdpc_pkg::RegDebounce;
  logic [bdpc_pkg::ThreshBits-1:0]   cfg_data_i    = '0;

  int mismatch_count;
  int pending_results;

  // Pace control: percentages of cycles each side spends idle.
  int samples_sent       = 0;
  int sender_idle_pct    = 38;
  int receiver_idle_pct  = 79;
  int stall_left         = 0;
  bit stall_done         = 1'b0;
  int cycle_count        = 0;

  always #ClkHalf clk_i = ~clk_i;

  button_debounce_press_classifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  bdpc_result_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_results)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side. Random back-pressure at the current pace, plus one long
  // stall while the sender keeps going, so the block backs up into its input.
  always @(negedge clk_i) begin
    if (rst_ni && !stall_done && samples_sent >= HoldOffStart) begin
      stall_left = HoldOffCycles;
      stall_done = 1'b1;
    end
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // One sample transfer. Entered and left at a falling edge; tvalid is
  // left high so back-to-back transfers need no second assignment.
  task automatic send_sample(input logic lvl);
    // first third: sender sparse-ish, receiver mostly stalled;
    // second third the other way round; last third flat out
    if (samples_sent < 520) begin
      sender_idle_pct   = 38;
      receiver_idle_pct = 79;
    end else if (samples_sent < 1040) begin
      sender_idle_pct   = 79;
      receiver_idle_pct = 38;
    end else begin
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
    end
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, lvl};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    samples_sent++;
  endtask

  // Fixed pattern, LSB first.
  task automatic send_pattern(input logic [31:0] bits, input int n);
    for (int k = 0; k < n; k++) send_sample(bits[k]);
  endtask

  // Stop offering and let every outstanding result come out.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Thresholds are only rewritten with the block drained.
  task automatic load_thresholds(input bdpc_pkg::thresh_t db, input bdpc_pkg::thresh_t lg,
                                 input bdpc_pkg::thresh_t vl, input bit poke_spare);
    logic [bdpc_pkg::CfgIndexBits-1:0] idx [4];
    bdpc_pkg::thresh_t                 val [4];
    int                                n;
    idx = '{bdpc_pkg::RegDebounce, bdpc_pkg::RegLong, bdpc_pkg::RegVeryLong, RegSpare};
    val = '{db, lg, vl, bdpc_pkg::thresh_t'($urandom)};
    n   = poke_spare ? 4 : 3;
    settle();
    for (int k = 0; k < n; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic chatter(input int n);
    repeat (n) send_sample(1'($urandom_range(0, 1)));
  endtask

  task automatic hold_level(input logic lvl, input int n);
    repeat (n) send_sample(lvl);
  endtask

  // Mostly bounce / steady press / bounce / steady release, with runs of
  // pure contact noise between. Lengths straddle the thresholds in use.
  task automatic press_traffic(input int n_samples, input int max_len);
    int target;
    target = samples_sent + n_samples;
    while (samples_sent < target) begin
      if ($urandom_range(0, 9) < 7) begin
        chatter($urandom_range(0, 3));
        hold_level(1'b0, $urandom_range(0, max_len));
        chatter($urandom_range(0, 3));
        hold_level(1'b1, $urandom_range(0, max_len));
      end else begin
        chatter($urandom_range(1, 6));
      end
    end
  endtask

  initial begin
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // --- directed ---
    // reset thresholds: a press that is far too short to be taken
    send_pattern(32'b011, 3);
    // all thresholds zero: very long fires on the accepting tick,
    // release after it gives no click
    load_thresholds(16'd0, 16'd0, 16'd0, 1'b0);
    send_pattern(32'b1100, 4);
    // long press two ticks in, very long out of reach
    load_thresholds(16'd1, 16'd2, 16'hFFFF, 1'b0);
    send_pattern(32'b1110_0000, 8);
    // plain click on release
    load_thresholds(16'd1, 16'hFFFF, 16'hFFFF, 1'b0);
    send_pattern(32'b111000, 6);
    // debounce at the counter maximum never accepts; spare index ignored
    load_thresholds(16'hFFFF, 16'd0, 16'd0, 1'b1);
    send_pattern(32'b00, 2);

    // --- random traffic under several threshold sets ---
    load_thresholds(16'd50, 16'd1000, 16'd5000, 1'b0);
    press_traffic(190, 120);
    load_thresholds(16'd0, 16'd5, 16'd12, 1'b0);
    press_traffic(200, 30);
    // very long below long: long never gets its own event
    load_thresholds(16'd3, 16'd20, 16'd10, 1'b0);
    press_traffic(200, 40);
    load_thresholds(16'd2, 16'd0, 16'hFFFF, 1'b0);
    press_traffic(180, 25);
    load_thresholds(bdpc_pkg::thresh_t'($urandom_range(0, 6)),
                    bdpc_pkg::thresh_t'($urandom_range(0, 40)),
                    bdpc_pkg::thresh_t'($urandom_range(0, 60)), 1'b1);
    press_traffic(220, 70);
    load_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    press_traffic(50, 10);
    load_thresholds(bdpc_pkg::thresh_t'($urandom_range(0, 6)),
                    bdpc_pkg::thresh_t'($urandom_range(0, 40)),
                    bdpc_pkg::thresh_t'($urandom_range(0, 60)), 1'b0);
    press_traffic(290, 70);

    settle();
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
